[rtl/kfq_pkg.sv]
// Package for the keyed FIFO queue unit: transaction structs, command and
// status codes, and the back-end state encoding. No dependencies.
package kfq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_KEY_BITS    = 16;
  localparam int KEY_W           = 16;   // width of the key field on the ports
  localparam int HANDLE_W        = 64;
  localparam int CMDQ_DEPTH      = 2;    // command queue between front and back

  // op field codes
  localparam logic [2:0] OP_ENQ  = 3'd0;
  localparam logic [2:0] OP_DEQ  = 3'd1;
  localparam logic [2:0] OP_UPD  = 3'd2;
  localparam logic [2:0] OP_DEL  = 3'd3;
  localparam logic [2:0] OP_DISP = 3'd4;

  // status field codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_EMPTY    = 2'd1;
  localparam logic [1:0] STAT_NOTFOUND = 2'd2;
  localparam logic [1:0] STAT_FULL     = 2'd3;

  typedef enum logic [2:0] {
    CMD_ENQ,
    CMD_DEQ,
    CMD_UPD,
    CMD_DEL,
    CMD_DISP
  } cmd_e_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_DISP
  } back_state_t;

  typedef struct packed {
    logic [2:0]          op;
    logic [KEY_W-1:0]    order_key;
    logic [HANDLE_W-1:0] customer_handle;
    logic [HANDLE_W-1:0] items_handle;
    logic [HANDLE_W-1:0] time_handle;
  } in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [KEY_W-1:0]    out_key;
    logic [HANDLE_W-1:0] out_customer;
    logic [HANDLE_W-1:0] out_items;
    logic [HANDLE_W-1:0] out_time;
    logic                last;
  } out_t;

  // classified command, key already masked
  typedef struct packed {
    cmd_e_t              cmd;
    logic [KEY_W-1:0]    order_key;
    logic [HANDLE_W-1:0] customer_handle;
    logic [HANDLE_W-1:0] items_handle;
    logic [HANDLE_W-1:0] time_handle;
  } cmd_t;

endpackage

[rtl/keyed_fifo_queue_unit.sv]
// Top level of the keyed FIFO queue unit: front end, command queue and
// back end. Uses kfq_pkg, kfq_front, kfq_back (and kfq_ram through kfq_back).

// An ordered store of up to QUEUE_DEPTH records (key plus customer, items and
// time handles), oldest first. Drive start with a transaction on in_data; it
// is taken when busy is low. The front end classifies the op, masks the key
// to KEY_BITS and drops op codes 5 to 7 without a result; up to two commands
// wait in a queue, so busy rises only when both slots are taken. Results come
// out on out_data for exactly one cycle, flagged by out_valid, and the
// receiver cannot stall them: sample every cycle where out_valid is high.
// Each command gives one result with last set, except display, which gives
// one result per record, last set on the newest. In the back end, enqueue
// writes the record directly; update and delete walk the records oldest
// first up to the first key match and answer not found if none matches;
// dequeue takes the oldest record. Dequeue and delete then close the gap
// by moving every later record down one slot; display walks all records.
// Dequeue, delete and display on an empty queue answer without a walk. The
// result is registered and leaves in the cycle after the one that decides
// it. The record store has a single read port per RAM, so each walk moves
// one record a cycle. Commands wait in the front-end queue before the back
// end sees them. No clearing pass is needed after reset.
module keyed_fifo_queue_unit #(
  parameter int QUEUE_DEPTH = kfq_pkg::DEF_QUEUE_DEPTH,
  parameter int KEY_BITS    = kfq_pkg::DEF_KEY_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  kfq_pkg::in_t  in_data,
  output logic          out_valid,
  output kfq_pkg::out_t out_data
);

  // classified command handed from front to back
  logic          q_valid;
  logic          q_pop;
  kfq_pkg::cmd_t q_cmd;

  // accept, classify and hold commands
  kfq_front #(
    .KEY_BITS(KEY_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  // execute one command at a time against the record store
  kfq_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .KEY_BITS   (KEY_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[rtl/kfq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/kfq_front.sv]
// Front end: accepts input transactions, classifies the op, masks the key
// and holds commands in a short queue for the back end. Uses kfq_pkg.
module kfq_front #(
  parameter int KEY_BITS = kfq_pkg::DEF_KEY_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  kfq_pkg::in_t  in_data,
  output logic          q_valid,
  output kfq_pkg::cmd_t q_cmd,
  input  logic          q_pop
);

  localparam int KW = (KEY_BITS < kfq_pkg::KEY_W) ? KEY_BITS : kfq_pkg::KEY_W;
  localparam logic [kfq_pkg::KEY_W-1:0] KEY_MASK =
    kfq_pkg::KEY_W'((32'd1 << KW) - 32'd1);
  localparam int QW = (kfq_pkg::CMDQ_DEPTH > 1) ? $clog2(kfq_pkg::CMDQ_DEPTH) : 1;
  localparam int FW = $clog2(kfq_pkg::CMDQ_DEPTH + 1);

  kfq_pkg::cmd_t slot_r [kfq_pkg::CMDQ_DEPTH];
  logic [QW-1:0] wptr_r, wptr_nxt;
  logic [QW-1:0] rptr_r, rptr_nxt;
  logic [FW-1:0] fill_r, fill_nxt;

  kfq_pkg::cmd_t dec_cmd;
  logic          dec_ok;
  logic          push;

  // classify; unused op codes are dropped here
  always_comb begin
    dec_cmd.cmd             = kfq_pkg::CMD_ENQ;
    dec_cmd.order_key       = in_data.order_key & KEY_MASK;
    dec_cmd.customer_handle = in_data.customer_handle;
    dec_cmd.items_handle    = in_data.items_handle;
    dec_cmd.time_handle     = in_data.time_handle;
    dec_ok                  = 1'b1;
    unique case (in_data.op)
      kfq_pkg::OP_ENQ:  dec_cmd.cmd = kfq_pkg::CMD_ENQ;
      kfq_pkg::OP_DEQ:  dec_cmd.cmd = kfq_pkg::CMD_DEQ;
      kfq_pkg::OP_UPD:  dec_cmd.cmd = kfq_pkg::CMD_UPD;
      kfq_pkg::OP_DEL:  dec_cmd.cmd = kfq_pkg::CMD_DEL;
      kfq_pkg::OP_DISP: dec_cmd.cmd = kfq_pkg::CMD_DISP;
      default:          dec_ok      = 1'b0;
    endcase
  end

  assign busy    = (fill_r == FW'(kfq_pkg::CMDQ_DEPTH));
  assign push    = start && !busy && dec_ok;
  assign q_valid = (fill_r != '0);
  assign q_cmd   = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    fill_nxt = fill_r;
    if (push) begin
      wptr_nxt = (wptr_r == QW'(kfq_pkg::CMDQ_DEPTH - 1)) ? '0 : wptr_r + QW'(1);
    end
    if (q_pop) begin
      rptr_nxt = (rptr_r == QW'(kfq_pkg::CMDQ_DEPTH - 1)) ? '0 : rptr_r + QW'(1);
    end
    if (push && !q_pop) begin
      fill_nxt = fill_r + FW'(1);
    end else if (!push && q_pop) begin
      fill_nxt = fill_r - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= dec_cmd;
    end
  end

endmodule

[rtl/kfq_back.sv]
// Back end: executes queued commands against the record store (three RAMs:
// keys, items handles, customer and time handles). Uses kfq_pkg and kfq_ram.
module kfq_back #(
  parameter int QUEUE_DEPTH = kfq_pkg::DEF_QUEUE_DEPTH,
  parameter int KEY_BITS    = kfq_pkg::DEF_KEY_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  kfq_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  output kfq_pkg::out_t out_data
);

  localparam int KW = (KEY_BITS < kfq_pkg::KEY_W) ? KEY_BITS : kfq_pkg::KEY_W;
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int HW = kfq_pkg::HANDLE_W;
  localparam int RW = 2 * HW;

  kfq_pkg::back_state_t state_r, state_nxt;
  kfq_pkg::cmd_t        cmd_r, cmd_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        ptr_r, ptr_nxt;
  logic [CW-1:0]        tag_r, tag_nxt;
  logic                 pend_r, pend_nxt;
  logic                 out_valid_r, out_valid_nxt;
  kfq_pkg::out_t        out_r, out_nxt;

  logic          key_we, items_we, rest_we;
  logic [AW-1:0] waddr, raddr;
  logic [KW-1:0] key_wdata, key_rd;
  logic [HW-1:0] items_wdata, items_rd;
  logic [RW-1:0] rest_wdata, rest_rd;

  logic issue, hit, walk_done, full, empty;

  kfq_ram #(.WIDTH(KW), .DEPTH(QUEUE_DEPTH)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(waddr), .wdata(key_wdata),
    .raddr(raddr), .rdata(key_rd)
  );

  kfq_ram #(.WIDTH(HW), .DEPTH(QUEUE_DEPTH)) u_items_ram (
    .clk(clk), .we(items_we), .waddr(waddr), .wdata(items_wdata),
    .raddr(raddr), .rdata(items_rd)
  );

  kfq_ram #(.WIDTH(RW), .DEPTH(QUEUE_DEPTH)) u_rest_ram (
    .clk(clk), .we(rest_we), .waddr(waddr), .wdata(rest_wdata),
    .raddr(raddr), .rdata(rest_rd)
  );

  assign full      = (count_r == CW'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign issue     = (ptr_r < count_r);
  assign walk_done = !issue && !pend_r;
  // dequeue takes whatever record comes back first
  assign hit       = pend_r && ((cmd_r.cmd == kfq_pkg::CMD_DEQ) ||
                                (key_rd == cmd_r.order_key[KW-1:0]));
  assign raddr     = ptr_r[AW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kfq_pkg::S_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.cmd)
            kfq_pkg::CMD_ENQ:  state_nxt = kfq_pkg::S_IDLE;
            kfq_pkg::CMD_UPD:  state_nxt = kfq_pkg::S_SEARCH;
            kfq_pkg::CMD_DISP: state_nxt = empty ? kfq_pkg::S_IDLE : kfq_pkg::S_DISP;
            default:           state_nxt = empty ? kfq_pkg::S_IDLE : kfq_pkg::S_SEARCH;
          endcase
        end
      end
      kfq_pkg::S_SEARCH: begin
        if (hit) begin
          state_nxt = (cmd_r.cmd == kfq_pkg::CMD_UPD) ? kfq_pkg::S_IDLE : kfq_pkg::S_SHIFT;
        end else if (walk_done) begin
          state_nxt = kfq_pkg::S_IDLE;
        end
      end
      kfq_pkg::S_SHIFT,
      kfq_pkg::S_DISP: begin
        if (walk_done) begin
          state_nxt = kfq_pkg::S_IDLE;
        end
      end
      default: state_nxt = kfq_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_pop         = 1'b0;
    cmd_nxt       = cmd_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    tag_nxt       = ptr_r;
    pend_nxt      = 1'b0;
    key_we        = 1'b0;
    items_we      = 1'b0;
    rest_we       = 1'b0;
    waddr         = tag_r[AW-1:0];
    key_wdata     = key_rd;
    items_wdata   = items_rd;
    rest_wdata    = rest_rd;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    out_nxt.last  = 1'b1;
    unique case (state_r)
      kfq_pkg::S_IDLE: begin
        ptr_nxt     = '0;
        waddr       = count_r[AW-1:0];
        key_wdata   = q_cmd.order_key[KW-1:0];
        items_wdata = q_cmd.items_handle;
        rest_wdata  = {q_cmd.customer_handle, q_cmd.time_handle};
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          unique case (q_cmd.cmd)
            kfq_pkg::CMD_ENQ: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_nxt.status = kfq_pkg::STAT_FULL;
              end else begin
                key_we    = 1'b1;
                items_we  = 1'b1;
                rest_we   = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            kfq_pkg::CMD_UPD: ;
            default: begin
              // dequeue, delete and display on an empty queue
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = kfq_pkg::STAT_EMPTY;
              end
            end
          endcase
        end
      end
      kfq_pkg::S_SEARCH: begin
        if (issue) begin
          ptr_nxt  = ptr_r + CW'(1);
          pend_nxt = 1'b1;
        end
        if (hit) begin
          out_valid_nxt   = 1'b1;
          out_nxt.out_key = kfq_pkg::KEY_W'(key_rd);
          if (cmd_r.cmd == kfq_pkg::CMD_UPD) begin
            items_we          = 1'b1;
            items_wdata       = cmd_r.items_handle;
            out_nxt.out_items = cmd_r.items_handle;
          end else begin
            // close the gap: move every later record down one slot
            ptr_nxt  = tag_r + CW'(1);
            pend_nxt = 1'b0;
          end
        end else if (walk_done) begin
          out_valid_nxt  = 1'b1;
          out_nxt.status = kfq_pkg::STAT_NOTFOUND;
        end
      end
      kfq_pkg::S_SHIFT: begin
        if (issue) begin
          ptr_nxt  = ptr_r + CW'(1);
          pend_nxt = 1'b1;
        end
        waddr = AW'(tag_r - CW'(1));
        if (pend_r) begin
          key_we   = 1'b1;
          items_we = 1'b1;
          rest_we  = 1'b1;
        end
        if (walk_done) begin
          count_nxt = count_r - CW'(1);
        end
      end
      kfq_pkg::S_DISP: begin
        if (issue) begin
          ptr_nxt  = ptr_r + CW'(1);
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          out_valid_nxt        = 1'b1;
          out_nxt.out_key      = kfq_pkg::KEY_W'(key_rd);
          out_nxt.out_customer = rest_rd[RW-1:HW];
          out_nxt.out_items    = items_rd;
          out_nxt.out_time     = rest_rd[HW-1:0];
          out_nxt.last         = (tag_r == count_r - CW'(1));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kfq_pkg::S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    ptr_r <= ptr_nxt;
    tag_r <= tag_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[tb/testbench.sv]
// Self-checking testbench for keyed_fifo_queue_unit: directed and random command
// streams are checked against a behavioral queue model kept inside the bench.
// Depends on kfq_pkg and the RTL of keyed_fifo_queue_unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kfq_pkg::*;

  localparam int QDEPTH = 16;
  localparam int KBITS  = 16;
  localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((64'd1 << KBITS) - 64'd1);
  // Allow plenty of margin over the longest command, a head delete of a full queue.
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic out_valid;
  in_t  in_data;
  out_t out_data;

  keyed_fifo_queue_unit #(
    .QUEUE_DEPTH (QDEPTH),
    .KEY_BITS    (KBITS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // 4 ns period, first rising edge at 2 ns.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Mirror of the record store, oldest record at index 0.
  logic [KEY_W-1:0]    rec_key   [QDEPTH];
  logic [HANDLE_W-1:0] rec_cust  [QDEPTH];
  logic [HANDLE_W-1:0] rec_items [QDEPTH];
  logic [HANDLE_W-1:0] rec_stamp [QDEPTH];
  int                  rec_count = 0;

  // Results predicted but not yet seen on the output, oldest first.
  out_t pending_results[$];

  int idle_pct     = 0;
  int err_count    = 0;
  int quiet_cycles = 0;

  function automatic out_t make_result(logic [1:0] st, logic [KEY_W-1:0] key,
                                       logic [HANDLE_W-1:0] cust,
                                       logic [HANDLE_W-1:0] items,
                                       logic [HANDLE_W-1:0] stamp, logic last);
    out_t r;
    r.status       = st;
    r.out_key      = key;
    r.out_customer = cust;
    r.out_items    = items;
    r.out_time     = stamp;
    r.last         = last;
    return r;
  endfunction

  function automatic in_t make_command(logic [2:0] op, logic [KEY_W-1:0] key,
                                       logic [HANDLE_W-1:0] cust,
                                       logic [HANDLE_W-1:0] items,
                                       logic [HANDLE_W-1:0] stamp);
    in_t c;
    c.op              = op;
    c.order_key       = key;
    c.customer_handle = cust;
    c.items_handle    = items;
    c.time_handle     = stamp;
    return c;
  endfunction

  // Position of the oldest record with this key, or -1.
  function automatic int find_record(logic [KEY_W-1:0] key);
    int i;
    for (i = 0; i < rec_count; i++)
      if (rec_key[i] == key) return i;
    return -1;
  endfunction

  // Remove one record and close the gap, keeping order.
  task automatic remove_record(input int pos);
    int i;
    for (i = pos; i + 1 < rec_count; i++) begin
      rec_key[i]   = rec_key[i + 1];
      rec_cust[i]  = rec_cust[i + 1];
      rec_items[i] = rec_items[i + 1];
      rec_stamp[i] = rec_stamp[i + 1];
    end
    rec_count--;
  endtask

  // Advance the queue model by one accepted command and queue up what the
  // unit must answer.
  task automatic apply_command(input in_t cmd);
    logic [KEY_W-1:0] key;
    int               pos;
    int               i;
    key = cmd.order_key & KEY_MASK;
    case (cmd.op)
      OP_ENQ: begin
        if (rec_count >= QDEPTH) begin
          pending_results.push_back(make_result(STAT_FULL, '0, '0, '0, '0, 1'b1));
        end else begin
          rec_key[rec_count]   = key;
          rec_cust[rec_count]  = cmd.customer_handle;
          rec_items[rec_count] = cmd.items_handle;
          rec_stamp[rec_count] = cmd.time_handle;
          rec_count++;
          pending_results.push_back(make_result(STAT_OK, '0, '0, '0, '0, 1'b1));
        end
      end
      OP_DEQ: begin
        if (rec_count == 0) begin
          pending_results.push_back(make_result(STAT_EMPTY, '0, '0, '0, '0, 1'b1));
        end else begin
          pending_results.push_back(make_result(STAT_OK, rec_key[0], '0, '0, '0, 1'b1));
          remove_record(0);
        end
      end
      OP_UPD: begin
        pos = find_record(key);
        if (pos < 0) begin
          pending_results.push_back(make_result(STAT_NOTFOUND, '0, '0, '0, '0, 1'b1));
        end else begin
          rec_items[pos] = cmd.items_handle;
          pending_results.push_back(make_result(STAT_OK, key, '0, cmd.items_handle,
                                                '0, 1'b1));
        end
      end
      OP_DEL: begin
        pos = find_record(key);
        if (rec_count == 0) begin
          pending_results.push_back(make_result(STAT_EMPTY, '0, '0, '0, '0, 1'b1));
        end else if (pos < 0) begin
          pending_results.push_back(make_result(STAT_NOTFOUND, '0, '0, '0, '0, 1'b1));
        end else begin
          pending_results.push_back(make_result(STAT_OK, key, '0, '0, '0, 1'b1));
          remove_record(pos);
        end
      end
      OP_DISP: begin
        if (rec_count == 0) begin
          pending_results.push_back(make_result(STAT_EMPTY, '0, '0, '0, '0, 1'b1));
        end else begin
          for (i = 0; i < rec_count; i++)
            pending_results.push_back(make_result(STAT_OK, rec_key[i], rec_cust[i],
                                                  rec_items[i], rec_stamp[i],
                                                  i + 1 == rec_count));
        end
      end
      default: begin
        // op codes 5 to 7: dropped by the front end, no result, no state change
      end
    endcase
  endtask

  // Present one command and hold it until the unit takes it. start is left
  // high afterwards so back-to-back transactions need no dead cycle; the next
  // call or the drain lowers it.
  task automatic issue_command(input in_t cmd);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= cmd;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    apply_command(cmd);
  endtask

  // Drop start and wait for every predicted result, then let the back end
  // settle in case an ignored command is still moving through it.
  task automatic drain_results;
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Check every result against the oldest prediction. The unit cannot be
  // stalled, so sample each cycle; the values read here are the ones from
  // before the edge.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d key=%h cust=%h items=%h time=%h last=%b",
                 $time, out_data.status, out_data.out_key, out_data.out_customer,
                 out_data.out_items, out_data.out_time, out_data.last);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data !== want || out_valid !== 1'b1) begin
          $display("%0t: mismatch expected status=%0d key=%h cust=%h items=%h time=%h last=%b",
                   $time, want.status, want.out_key, want.out_customer,
                   want.out_items, want.out_time, want.last);
          $display("%0t:          actual   status=%0d key=%h cust=%h items=%h time=%h last=%b",
                   $time, out_data.status, out_data.out_key, out_data.out_customer,
                   out_data.out_items, out_data.out_time, out_data.last);
          err_count++;
        end
      end
    end
  end

  // Watchdog: end the run if neither a command nor a result moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic logic [HANDLE_W-1:0] random_handle();
    return {$urandom, $urandom};
  endfunction

  // Mostly keys already in the queue or from a tiny pool, so that matches and
  // duplicates are common; now and then a full-width key.
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (rec_count > 0 && r < 55) return rec_key[$urandom_range(rec_count - 1)];
    if (r < 85) return KEY_W'($urandom_range(7));
    return KEY_W'($urandom);
  endfunction

  // Filling phases lean on enqueue to reach a full queue, draining phases on
  // dequeue and delete to reach an empty one.
  function automatic in_t random_command(bit filling);
    int         r;
    logic [2:0] op;
    r = $urandom_range(99);
    if (filling)
      op = (r < 60) ? OP_ENQ : (r < 68) ? OP_DEQ : (r < 80) ? OP_UPD :
           (r < 88) ? OP_DEL : (r < 96) ? OP_DISP : 3'($urandom_range(5, 7));
    else
      op = (r < 15) ? OP_ENQ : (r < 45) ? OP_DEQ : (r < 58) ? OP_UPD :
           (r < 82) ? OP_DEL : (r < 95) ? OP_DISP : 3'($urandom_range(5, 7));
    return make_command(op, pick_key(), random_handle(), random_handle(),
                        random_handle());
  endfunction

  // Dequeue, delete, update and display on an empty queue: empty status, update answers not found.
  task automatic test_empty_queue;
    issue_command(make_command(OP_DEQ, 16'h0001, '0, '0, '0));
    issue_command(make_command(OP_DEL, 16'h0001, '0, '0, '0));
    issue_command(make_command(OP_UPD, 16'h0001, '0, '1, '0));
    issue_command(make_command(OP_DISP, '0, '0, '0, '0));
  endtask

  // Fill to capacity with extreme keys, handles and duplicate keys, push one
  // more to hit the full case, then read everything back.
  task automatic test_fill_and_overflow;
    int                  i;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] pat;
    for (i = 0; i < QDEPTH; i++) begin
      key = (i == 1) ? 16'hFFFF : KEY_W'(i % 5);
      pat = (i == 0) ? '0 : (i == 1) ? '1 : (i == 2) ? 64'hAAAA_AAAA_AAAA_AAAA :
            (i == 3) ? 64'h5555_5555_5555_5555 : random_handle();
      issue_command(make_command(OP_ENQ, key, pat, ~pat, random_handle()));
    end
    issue_command(make_command(OP_ENQ, 16'h7777, '1, '1, '1));
    issue_command(make_command(OP_DISP, '0, '0, '0, '0));
  endtask

  // Keyed operations on a populated queue: duplicates hit the oldest match,
  // missing keys change nothing, unused op codes are dropped.
  task automatic test_keyed_ops;
    issue_command(make_command(OP_UPD, 16'h0003, '0, 64'hDEAD_BEEF_0123_4567, '0));
    issue_command(make_command(OP_DEL, 16'h0002, '0, '0, '0));
    issue_command(make_command(OP_UPD, 16'h1234, '0, '1, '0));
    issue_command(make_command(OP_DEL, 16'hBEEF, '0, '0, '0));
    issue_command(make_command(OP_DEQ, '0, '0, '0, '0));
    issue_command(make_command(3'd6, 16'h0003, '1, '1, '1));
  endtask

  // Random commands under one sender idle rate; dropped op codes do not count.
  task automatic test_random(input int pct, input int n_items);
    int  n_sent;
    in_t cmd;
    idle_pct = pct;
    n_sent   = 0;
    while (n_sent < n_items) begin
      cmd = random_command((n_sent % 80) < 45);
      issue_command(cmd);
      if (cmd.op <= OP_DISP) n_sent++;
    end
  endtask

  initial begin
    // Hold reset with every input at a known value.
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    idle_pct = 35;
    test_empty_queue;
    test_fill_and_overflow;
    test_keyed_ops;
    test_random(35, 170);
    test_random(55, 165);
    test_random(0, 165);
    drain_results;

    if (err_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
